// File: src/scrc_pkg.sv
package scrc_pkg;

  localparam int unsigned SLOTS_DEF    = 8;
  localparam int unsigned MAX_RAYS_DEF = 1024;
  localparam int unsigned DUP_MAX      = 65535;

  typedef enum logic [1:0] {
    CMD_OBSERVE = 2'd0,
    CMD_SUMMARY = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // result kinds
  localparam logic KIND_MASK    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

// File: src/scan_cycle_ray_completeness_top.sv
// Scan-cycle ray completeness tracker.
// Input stream (s_axis_*): one command per transaction. tdata carries
// cycle_tag, time_tag, ray_count, index_present, ray_idx; tuser
// carries cmd (0 observe, 1 summary, 2 clear, 3 no-op).
// Output stream (m_axis_*): missing-index mask words (tuser kind 0) and a
// final summary item (kind 1, tlast 1) for each summary command.
// Observe: accept, slot lookup, bitmap memory read, write back; only accept
// and lookup when no in-range index comes with it or it is dropped.
// Summary: accept and lookup, then a read and an emit for each 64-index mask
// word (up to WORDS, 16 by default), one last read and the final item. The
// unused words of the freed slot are then cleared, one per cycle.
// The first result follows lookup and a read, or lookup alone if nothing matches.
// Clear: accept, lookup, then a sweep over all SLOTS*WORDS bitmap words.
// After reset the block runs the same clearing sweep before it takes input;
// that pass covers SLOTS*ceil(MAX_RAYS/64) words (128 by default).
// When the receiver stalls the result holds in the output register and the
// walk waits; no results are lost. Input is taken only while the block is
// idle, one command at a time.
module scan_cycle_ray_completeness_top
  import scrc_pkg::*;
#(
  parameter int unsigned SLOTS    = SLOTS_DEF,
  parameter int unsigned MAX_RAYS = MAX_RAYS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] cycle_tag, [95:32] time_tag, [106:96] ray_count,
  // [107] index_present, [123:108] ray_idx, [127:124] zero
  input  logic [127:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [3:0] word_index, [67:4] missing_mask, [68] found, [100:69] out_cycle_tag,
  // [164:101] out_time_tag, [175:165] expected count, [186:176] received count,
  // [202:187] duplicate count, [203] complete, [205:204] flags, [207:206] zero
  output logic [207:0] m_axis_tdata,
  // [0] kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);

  localparam int unsigned WORDS = (MAX_RAYS + 63) / 64;
  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned DEPTH = SLOTS * WORDS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RW    = $clog2(MAX_RAYS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_LOOK, ST_OBS_RD, ST_OBS_WR, ST_SUM_RD, ST_SUM_OUT, ST_FINAL
  } state_t;

  state_t state;

  // slot table
  logic [SLOTS-1:0] slot_valid;
  logic [31:0]      slot_cycle_tag [SLOTS];
  logic [63:0]      slot_time_tag  [SLOTS];
  logic [RW-1:0]    slot_expected  [SLOTS];
  logic [RW-1:0]    slot_received  [SLOTS];
  logic [15:0]      slot_duplicates[SLOTS];
  logic [SLOTS-1:0] slot_overflow;
  logic             table_full_drop;

  // bitmap memory
  logic [63:0] bitmap_mem [DEPTH];
  logic [63:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          rd_en, wr_en;
  logic [63:0]   wr_data;

  // captured command
  logic [1:0]   cmd;
  logic [31:0]  in_cycle_tag;
  logic [63:0]  in_time_tag;
  logic [10:0]  in_rays;
  logic         in_present;
  logic [15:0]  in_index;

  logic [SW-1:0] sel;
  logic          hit;
  logic [AW-1:0] sweep;
  logic [WW:0]   word_cnt;
  logic [WW:0]   nwords;
  logic          missing;

  // slot lookup
  logic [SW-1:0] tag_idx, time_idx, free_idx;
  logic          tag_hit, time_hit, free_hit;
  always_comb begin
    tag_idx = '0; time_idx = '0; free_idx = '0;
    tag_hit = 1'b0; time_hit = 1'b0; free_hit = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_cycle_tag[i] == in_cycle_tag) begin
        tag_hit = 1'b1; tag_idx = SW'(i);
      end
      if (slot_valid[i] && slot_time_tag[i] == in_time_tag) begin
        time_hit = 1'b1; time_idx = SW'(i);
      end
      if (!slot_valid[i]) begin
        free_hit = 1'b1; free_idx = SW'(i);
      end
    end
  end

  // observe helpers
  logic [RW-1:0] rays_sat;
  logic          idx_over;
  logic [5:0]    bit_pos;
  logic [AW-1:0] obs_addr;
  assign rays_sat = (32'(in_rays) > MAX_RAYS) ? RW'(MAX_RAYS) : RW'(in_rays);
  assign idx_over = (32'(in_index) >= 32'(MAX_RAYS));
  assign bit_pos  = in_index[5:0];
  assign obs_addr = AW'(32'(sel) * 32'(WORDS) + 32'(in_index >> 6));

  // summary helpers
  logic [AW-1:0] sum_addr;
  logic [31:0]   rem;
  logic [63:0]   valid_mask;
  logic [63:0]   cur_mask;
  assign sum_addr = AW'(32'(sel) * 32'(WORDS) + 32'(word_cnt));
  assign rem = 32'(slot_expected[sel]) - 32'(word_cnt) * 32'd64;
  assign valid_mask = (rem >= 32'd64) ? {64{1'b1}} : ((64'd1 << rem[5:0]) - 64'd1);
  assign cur_mask = ~rd_data & valid_mask;

  assign s_axis_tready = (state == ST_IDLE);

  // output register handshake
  logic out_free, out_load;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = out_free && (state == ST_SUM_OUT || state == ST_FINAL);

  // end of a full sweep, or of the freed slot's last word after a summary
  logic sweep_done;
  assign sweep_done = (32'(sweep) == DEPTH - 1) ||
                      (hit && cmd == CMD_SUMMARY &&
                       32'(sweep) == 32'(sel) * WORDS + WORDS - 1);

  // memory
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= bitmap_mem[rd_addr];
    end
    if (wr_en) begin
      bitmap_mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    rd_en = 1'b0; rd_addr = obs_addr;
    wr_en = 1'b0; wr_addr = sweep; wr_data = '0;
    unique case (state)
      ST_CLEAR: wr_en = 1'b1;
      ST_OBS_RD: rd_en = 1'b1;
      ST_OBS_WR: begin
        wr_en = 1'b1; wr_addr = obs_addr;
        wr_data = rd_data | (64'd1 << bit_pos);
      end
      ST_SUM_RD: begin
        rd_en = 1'b1; rd_addr = sum_addr;
      end
      ST_SUM_OUT: begin
        wr_en = out_free; wr_addr = sum_addr;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sweep <= '0;
      hit <= 1'b0;
      slot_valid <= '0;
      slot_overflow <= '0;
      table_full_drop <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (sweep_done) begin
            sweep <= '0;
            hit <= 1'b0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + AW'(1);
          end
        end
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            cmd          <= s_axis_tuser;
            in_cycle_tag <= s_axis_tdata[31:0];
            in_time_tag  <= s_axis_tdata[95:32];
            in_rays      <= s_axis_tdata[106:96];
            in_present   <= s_axis_tdata[107];
            in_index     <= s_axis_tdata[123:108];
            state        <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          word_cnt <= '0;
          missing  <= 1'b0;
          unique case (cmd)
            CMD_OBSERVE: begin
              if (tag_hit) begin
                sel <= tag_idx;
                if (in_rays != '0) slot_expected[tag_idx] <= rays_sat;
                state <= (in_present && !idx_over) ? ST_OBS_RD : ST_IDLE;
                if (in_present && idx_over) slot_overflow[tag_idx] <= 1'b1;
              end else if (free_hit) begin
                sel <= free_idx;
                slot_valid[free_idx]      <= 1'b1;
                slot_cycle_tag[free_idx]  <= in_cycle_tag;
                slot_time_tag[free_idx]   <= in_time_tag;
                slot_expected[free_idx]   <= (in_rays != '0) ? rays_sat : '0;
                slot_received[free_idx]   <= '0;
                slot_duplicates[free_idx] <= '0;
                slot_overflow[free_idx]   <= in_present && idx_over;
                state <= (in_present && !idx_over) ? ST_OBS_RD : ST_IDLE;
              end else begin
                table_full_drop <= 1'b1;
                state <= ST_IDLE;
              end
            end
            CMD_SUMMARY: begin
              hit <= time_hit;
              sel <= time_idx;
              nwords <= (WW+1)'((32'(slot_expected[time_idx]) + 32'd63) >> 6);
              state <= time_hit ? ST_SUM_RD : ST_FINAL;
            end
            CMD_CLEAR: begin
              slot_valid <= '0;
              slot_overflow <= '0;
              table_full_drop <= 1'b0;
              sweep <= '0;
              state <= ST_CLEAR;
            end
            default: state <= ST_IDLE;
          endcase
        end
        ST_OBS_RD: state <= ST_OBS_WR;
        ST_OBS_WR: begin
          if (rd_data[bit_pos]) begin
            if (32'(slot_duplicates[sel]) < DUP_MAX)
              slot_duplicates[sel] <= slot_duplicates[sel] + 16'd1;
          end else begin
            slot_received[sel] <= slot_received[sel] + RW'(1);
          end
          state <= ST_IDLE;
        end
        ST_SUM_RD: begin
          state <= (word_cnt < nwords) ? ST_SUM_OUT : ST_FINAL;
        end
        ST_SUM_OUT: begin
          if (out_free) begin
            m_axis_tuser  <= KIND_MASK;
            m_axis_tlast  <= 1'b0;
            m_axis_tdata  <= {140'd0, cur_mask, 4'(word_cnt)};
            if (cur_mask != '0) missing <= 1'b1;
            word_cnt <= word_cnt + (WW+1)'(1);
            state <= ST_SUM_RD;
          end
        end
        ST_FINAL: begin
          if (out_free) begin
            m_axis_tuser  <= KIND_SUMMARY;
            m_axis_tlast  <= 1'b1;
            if (hit) begin
              m_axis_tdata <= {2'd0, table_full_drop, slot_overflow[sel],
                (slot_expected[sel] != '0 && slot_received[sel] == slot_expected[sel]
                 && slot_duplicates[sel] == '0 && !missing && !slot_overflow[sel]
                 && !table_full_drop),
                slot_duplicates[sel], 11'(slot_received[sel]), 11'(slot_expected[sel]),
                slot_time_tag[sel], slot_cycle_tag[sel], 1'b1, 64'd0, 4'd0};
              slot_valid[sel] <= 1'b0;
              // words beyond the expected count may hold bits from an earlier,
              // larger count: sweep the rest of the slot
              if (32'(nwords) < WORDS) begin
                sweep <= AW'(32'(sel) * 32'(WORDS) + 32'(nwords));
                word_cnt <= nwords;
                state <= ST_CLEAR;
              end else begin
                state <= ST_IDLE;
              end
            end else begin
              m_axis_tdata <= {2'd0, table_full_drop, 1'b0, 1'b0, 16'd0, 11'd0, 11'd0,
                64'd0, 32'd0, 1'b0, 64'd0, 4'd0};
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: tb/testbench.sv
module testbench;
  import scrc_pkg::*;

  localparam int NSLOT = 8;
  localparam int NRAYS = 1024;
  localparam int NWORD = 16;
  localparam int LIMIT = 2000000;

  // one result transaction, as it leaves the block
  typedef struct packed {
    logic        kind;
    logic [3:0]  word_index;
    logic [63:0] missing_mask;
    logic        found;
    logic [31:0] cyc;
    logic [63:0] ttag;
    logic [10:0] exp_rays;
    logic [10:0] rcv_rays;
    logic [15:0] dup_rays;
    logic        complete;
    logic [1:0]  flags;
    logic        last;
  } report_t;

  // table model and queue of reports still owed by the block
  class ray_scoreboard;
    bit          vld[NSLOT];
    bit [31:0]   cyc[NSLOT];
    bit [63:0]   ttag[NSLOT];
    int          expc[NSLOT];
    int          rcv[NSLOT];
    int          dup[NSLOT];
    bit          ovf[NSLOT];
    bit [63:0]   seen[NSLOT][NWORD];
    bit          drop;
    report_t     owed[$];
    int          errors;

    function void free_slot(int s);
      vld[s] = 0; cyc[s] = 0; ttag[s] = 0; expc[s] = 0;
      rcv[s] = 0; dup[s] = 0; ovf[s] = 0;
      for (int w = 0; w < NWORD; w++) seen[s][w] = 0;
    endfunction

    function void wipe();
      for (int s = 0; s < NSLOT; s++) free_slot(s);
      drop = 0;
    endfunction

    function int find_slot(bit [31:0] tag);
      for (int i = 0; i < NSLOT; i++) if (vld[i] && cyc[i] == tag) return i;
      return -1;
    endfunction

    function bit has_free();
      for (int i = 0; i < NSLOT; i++) if (!vld[i]) return 1;
      return 0;
    endfunction

    // append a report to the owed queue
    function void owe(report_t r);
      owed = {owed, r};
    endfunction

    // note an accepted command
    function void accept(cmd_t cmd, bit [31:0] tag, bit [63:0] tt, bit [10:0] rays,
                         bit pres, bit [15:0] idx);
      int s;
      report_t r;
      bit miss;
      bit [63:0] valid, m;
      int rem;
      s = -1;
      miss = 0;
      case (cmd)
        CMD_OBSERVE: begin
          s = find_slot(tag);
          if (s < 0) begin
            for (int i = 0; i < NSLOT; i++) if (!vld[i]) begin s = i; break; end
            if (s < 0) begin drop = 1; return; end
            free_slot(s);
            vld[s] = 1; cyc[s] = tag; ttag[s] = tt;
          end
          if (rays > 0) expc[s] = (rays > NRAYS) ? NRAYS : rays;
          if (!pres) return;
          if (idx >= NRAYS) begin ovf[s] = 1; return; end
          if (seen[s][idx >> 6][idx[5:0]]) begin
            if (dup[s] < DUP_MAX) dup[s]++;
          end else begin
            seen[s][idx >> 6][idx[5:0]] = 1;
            rcv[s]++;
          end
        end
        CMD_SUMMARY: begin
          for (int i = 0; i < NSLOT; i++)
            if (vld[i] && ttag[i] == tt) begin s = i; break; end
          r = '0;
          r.kind = KIND_SUMMARY;
          r.last = 1;
          if (s < 0) begin
            r.flags = {drop, 1'b0};
            owe(r);
            return;
          end
          for (int w = 0; w < (expc[s] + 63) / 64; w++) begin
            rem = expc[s] - w * 64;
            valid = (rem >= 64) ? '1 : ((64'd1 << rem) - 1);
            m = ~seen[s][w] & valid;
            if (m != 0) miss = 1;
            r = '0;
            r.kind = KIND_MASK;
            r.word_index = w[3:0];
            r.missing_mask = m;
            owe(r);
          end
          r = '0;
          r.kind = KIND_SUMMARY;
          r.found = 1;
          r.cyc = cyc[s];
          r.ttag = ttag[s];
          r.exp_rays = 11'(expc[s]);
          r.rcv_rays = 11'(rcv[s]);
          r.dup_rays = 16'(dup[s]);
          r.flags = {drop, ovf[s]};
          r.complete = expc[s] > 0 && rcv[s] == expc[s] && dup[s] == 0 && !miss &&
                       r.flags == 0;
          r.last = 1;
          owe(r);
          free_slot(s);
        end
        CMD_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    // compare one result against the oldest owed report
    function void check(report_t a);
      report_t e;
      if (owed.size() == 0) begin
        $error("unexpected result transaction kind=%0d", a.kind);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (a.kind != e.kind) begin
        $error("kind exp %0d got %0d", e.kind, a.kind); errors++; end
      if (a.word_index != e.word_index) begin
        $error("word_index exp %0d got %0d", e.word_index, a.word_index); errors++; end
      if (a.missing_mask != e.missing_mask) begin
        $error("missing_mask exp %h got %h", e.missing_mask, a.missing_mask); errors++; end
      if (a.found != e.found) begin
        $error("found exp %0d got %0d", e.found, a.found); errors++; end
      if (a.cyc != e.cyc) begin
        $error("out_cycle_tag exp %h got %h", e.cyc, a.cyc); errors++; end
      if (a.ttag != e.ttag) begin
        $error("out_time_tag exp %h got %h", e.ttag, a.ttag); errors++; end
      if (a.exp_rays != e.exp_rays) begin
        $error("expected_count exp %0d got %0d", e.exp_rays, a.exp_rays); errors++; end
      if (a.rcv_rays != e.rcv_rays) begin
        $error("received_count exp %0d got %0d", e.rcv_rays, a.rcv_rays); errors++; end
      if (a.dup_rays != e.dup_rays) begin
        $error("duplicate_count exp %0d got %0d", e.dup_rays, a.dup_rays); errors++; end
      if (a.complete != e.complete) begin
        $error("complete exp %0d got %0d", e.complete, a.complete); errors++; end
      if (a.flags != e.flags) begin
        $error("flags exp %0d got %0d", e.flags, a.flags); errors++; end
      if (a.last != e.last) begin
        $error("last exp %0d got %0d", e.last, a.last); errors++; end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [207:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;

  ray_scoreboard sb = new();
  bit            calm = 0;
  int            cycles = 0;

  scan_cycle_ray_completeness_top uut (.*);

  always #5 clk = ~clk;

  // receiver: random stall bursts, then checks on each accepted transaction
  always @(posedge clk) begin
    report_t a;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("** scan_cycle_ray_completeness_top: FAILED **");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      a.kind = m_axis_tuser;
      a.word_index = m_axis_tdata[3:0];
      a.missing_mask = m_axis_tdata[67:4];
      a.found = m_axis_tdata[68];
      a.cyc = m_axis_tdata[100:69];
      a.ttag = m_axis_tdata[164:101];
      a.exp_rays = m_axis_tdata[175:165];
      a.rcv_rays = m_axis_tdata[186:176];
      a.dup_rays = m_axis_tdata[202:187];
      a.complete = m_axis_tdata[203];
      a.flags = m_axis_tdata[205:204];
      a.last = m_axis_tlast;
      sb.check(a);
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (calm) m_axis_tready <= 1;
    else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_axis_tready <= 0;
    end else m_axis_tready <= 1;
  end

  // send one command, with an optional idle burst first; tvalid stays high
  // after acceptance until the next command or drain
  task automatic send(cmd_t cmd, bit [31:0] tag, bit [63:0] tt, bit [10:0] rays,
                      bit pres, bit [15:0] idx);
    int gap;
    gap = (!calm && $urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {4'b0, idx, pres, rays, tt, tag};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.accept(cmd, tag, tt, rays, pres, idx);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // one scan cycle: a handful of rays, with noise on later tags and counts
  task automatic one_cycle(bit [31:0] tag, bit [63:0] tt);
    int n, rays;
    bit [15:0] idx;
    rays = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 130);
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, rays + 2));
      send(CMD_OBSERVE, tag, (i == 0) ? tt : 64'($urandom), (i == 0) ? 11'(rays) :
           ($urandom_range(0, 3) == 0 ? 11'($urandom) : 11'd0),
           $urandom_range(0, 9) != 0, idx);
    end
    // full coverage of a small cycle now and then
    if ($urandom_range(0, 4) == 0 && rays <= 70) begin
      send(CMD_OBSERVE, tag, tt, 11'(rays), 1'b1, 16'd0);
      for (int i = 1; i < rays; i++) send(CMD_OBSERVE, tag, tt, '0, 1'b1, 16'(i));
    end
  endtask

  initial begin
    bit [63:0] tts[NSLOT];
    sb.wipe();
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed: max-size cycle, overflow index, dup, complete one-ray cycle, no-op, no match
    send(CMD_OBSERVE, 32'hFFFF_FFFF, '1, 11'd2047, 1'b1, 16'd1023);
    send(CMD_OBSERVE, 32'hFFFF_FFFF, 64'd5, '0, 1'b1, 16'hFFFF);
    send(CMD_OBSERVE, 32'hFFFF_FFFF, 64'd5, '0, 1'b1, 16'd1023);
    send(CMD_OBSERVE, 32'd0, 64'd0, 11'd1, 1'b1, 16'd0);
    send(CMD_OBSERVE, 32'd1, 64'd1, 11'd64, 1'b0, 16'd0);
    send(CMD_NONE, 32'd1, 64'd1, 11'd3, 1'b1, 16'd5);
    send(CMD_SUMMARY, '0, '1, '0, 1'b0, '0);
    send(CMD_SUMMARY, '0, 64'd0, '0, 1'b0, '0);
    send(CMD_SUMMARY, '0, 64'd1, '0, 1'b0, '0);
    send(CMD_SUMMARY, '0, 64'd77, '0, 1'b0, '0);
    // fill the table and overflow it
    for (int i = 0; i < NSLOT + 2; i++)
      send(CMD_OBSERVE, 32'(100 + i), 64'(200 + i), 11'd3, 1'b1, 16'd2);
    send(CMD_SUMMARY, '0, 64'd203, '0, 1'b0, '0);
    send(CMD_SUMMARY, '0, 64'd999, '0, 1'b0, '0);
    send(CMD_CLEAR, '1, '1, '1, 1'b1, '1);
    send(CMD_SUMMARY, '0, 64'd200, '0, 1'b0, '0);

    // repeated index on one slot
    send(CMD_OBSERVE, 32'h5A5A, 64'hABCD, 11'd2, 1'b1, 16'd0);
    for (int i = 0; i < 4; i++)
      send(CMD_OBSERVE, 32'h5A5A, 64'hABCD, '0, 1'b1, 16'd0);
    send(CMD_SUMMARY, '0, 64'hABCD, '0, 1'b0, '0);

    // random part: groups of cycles with random payloads, some noise
    for (int g = 0; g < 10; g++) begin
      int k;
      k = $urandom_range(1, NSLOT + 1);
      if (g >= 8) calm = 1;
      for (int j = 0; j < k; j++) begin
        tts[j % NSLOT] = ($urandom_range(0, 1)) ? 64'(j) : {$urandom, $urandom};
        one_cycle({4'($urandom_range(0, 3)), 28'(j)} ^ 32'($urandom_range(0, 1) << 31),
                  tts[j % NSLOT]);
      end
      for (int j = 0; j < k; j++) begin
        if ($urandom_range(0, 9) == 0)
          send(CMD_SUMMARY, '0, {$urandom, $urandom}, '0, 1'b0, '0);
        else
          send(CMD_SUMMARY, '0, 64'($urandom_range(0, 8)), '0, 1'b0, '0);
      end
      if ($urandom_range(0, 5) == 0) send(CMD_NONE, $urandom, {$urandom, $urandom},
                                          11'($urandom), 1'b1, 16'($urandom));
      if ($urandom_range(0, 6) == 0) begin
        drain();
        send(CMD_CLEAR, '0, '0, '0, 1'b0, '0);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("** scan_cycle_ray_completeness_top: PASSED **");
    else
      $display("** scan_cycle_ray_completeness_top: FAILED **");
    $finish;
  end
endmodule
